// File: sv/acd_pkg.sv
// Package for the TCP AccECN option detector: sizes, register indexes,
// exit reason codes and the transaction structs. No dependencies.
package acd_pkg;

    localparam int HEADER_BYTES = 64;
    localparam int ADDR_W       = $clog2(HEADER_BYTES);
    localparam int CNT_W        = $clog2(HEADER_BYTES + 1);
    localparam int SPACE_W      = 6;
    localparam int PADDR_W      = 4;

    localparam logic [ADDR_W-1:0] OFFSET_BYTE = ADDR_W'(12);
    localparam logic [ADDR_W-1:0] BASE_HEADER = ADDR_W'(20);
    localparam logic [CNT_W-1:0]  MIN_LOADED  = CNT_W'(13);

    localparam logic [7:0] KIND_EOL = 8'd0;
    localparam logic [7:0] KIND_NOP = 8'd1;

    localparam logic [7:0]  KIND_RESET   = 8'd254;
    localparam logic [15:0] MAGIC1_RESET = 16'hACC0;
    localparam logic [15:0] MAGIC2_RESET = 16'hACC1;

    typedef enum logic [1:0] {
        REG_KIND   = 2'd0,
        REG_MAGIC1 = 2'd1,
        REG_MAGIC2 = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        WHY_FOUND    = 3'd0,
        WHY_END      = 3'd1,
        WHY_USED_UP  = 3'd2,
        WHY_SHORT    = 3'd3,
        WHY_ZERO_LEN = 3'd4,
        WHY_TRUNC    = 3'd5
    } why_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       header_end;
    } in_item_t;

    typedef struct packed {
        logic       has_accecn;
        logic [2:0] exit_reason;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic [ADDR_W-1:0] rd_addr;
        logic [CNT_W-1:0]  fill_cnt;
    } store_req_t;

endpackage

// File: sv/acd_store.sv
// Header byte store: one write port, one registered read port.
// Reads at or beyond the fill count return zero. Depends on acd_pkg.
module acd_store
    import acd_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [HEADER_BYTES];
    logic [7:0] rdata_reg;
    logic       rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rdata_reg <= mem[req.rd_addr];
        rd_ok_reg <= (CNT_W'(req.rd_addr) < req.fill_cnt);
    end

    assign rd_data = rd_ok_reg ? rdata_reg : 8'd0;

endmodule

// File: sv/tcp_accecn_option_detector.sv
// Top level of the TCP AccECN option detector: APB registers, byte loading
// and the option walk sequencer. Depends on acd_pkg and acd_store.
//
//   channel  | direction | handshake          | payload
//   in       | input     | in_valid/in_stall  | in_item_t  (header_byte, header_end)
//   out      | output    | out_valid/out_stall| out_item_t (has_accecn, exit_reason)
//   config   | input     | APB psel/penable   | pwdata / prdata, 32 bits
//
// Header bytes load one per cycle while in_stall is low. The final byte starts the walk, one
// store read per cycle: the offset check, then per option its kind byte, then for other than
// no-operation bytes its magic (experimental options) and its length, and last the result post.
// in_stall is high for the whole walk and while the result waits for the output register.
// A posted result waits until taken; the next header loads meanwhile. Reset clears control only.
module tcp_accecn_option_detector
    import acd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_CHECK   = 10'b00_0000_0010,
        S_OFFSET  = 10'b00_0000_0100,
        S_KIND_RD = 10'b00_0000_1000,
        S_KIND    = 10'b00_0001_0000,
        S_MAGIC_H = 10'b00_0010_0000,
        S_MAGIC_L = 10'b00_0100_0000,
        S_XLEN    = 10'b00_1000_0000,
        S_LEN     = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [SPACE_W-1:0]  space_reg, space_next;
    logic [7:0]          magic_hi_reg, magic_hi_next;
    why_t                why_reg, why_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;
    logic [7:0]          kind_reg;
    logic [15:0]         magic1_reg;
    logic [15:0]         magic2_reg;

    store_req_t          sreq;
    logic [7:0]          rbyte;
    logic                in_take;
    logic                cfg_wr;
    reg_idx_t            reg_idx;
    logic [SPACE_W-1:0]  off_bytes;
    logic [8:0]          space_diff;
    logic [15:0]         magic;

    acd_store u_store (
        .clk     (clk),
        .req     (sreq),
        .rd_data (rbyte)
    );

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_RESET;
            magic1_reg <= MAGIC1_RESET;
            magic2_reg <= MAGIC2_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_KIND:   kind_reg   <= pwdata[7:0];
                REG_MAGIC1: magic1_reg <= pwdata[15:0];
                REG_MAGIC2: magic2_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KIND:   prdata = {24'd0, kind_reg};
            REG_MAGIC1: prdata = {16'd0, magic1_reg};
            REG_MAGIC2: prdata = {16'd0, magic2_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // shared compare/subtract unit: remaining space minus the byte just read
    assign space_diff = {3'd0, space_reg} - {1'b0, rbyte};
    assign off_bytes  = {rbyte[7:4], 2'b00};
    assign magic      = {magic_hi_reg, rbyte};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        space_next     = space_reg;
        magic_hi_next  = magic_hi_reg;
        why_next       = why_reg;
        out_valid_next = out_valid_reg & out_stall;
        out_data_next  = out_data_reg;

        sreq.wr_en     = 1'b0;
        sreq.wr_addr   = cnt_reg[ADDR_W-1:0];
        sreq.wr_data   = in_data.header_byte;
        sreq.rd_addr   = pos_reg;
        sreq.fill_cnt  = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (cnt_reg < CNT_W'(HEADER_BYTES))
                    begin
                        sreq.wr_en = 1'b1;
                        cnt_next   = cnt_reg + CNT_W'(1);
                    end
                    if (in_data.header_end)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                sreq.rd_addr = OFFSET_BYTE;
                if (cnt_reg < MIN_LOADED)
                begin
                    why_next   = WHY_TRUNC;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_OFFSET;
                end
            end
            S_OFFSET:
            begin
                pos_next   = BASE_HEADER;
                space_next = off_bytes - SPACE_W'(BASE_HEADER);
                if (cnt_reg < CNT_W'(off_bytes))
                begin
                    why_next   = WHY_TRUNC;
                    state_next = S_DONE;
                end
                else if (off_bytes <= SPACE_W'(BASE_HEADER))
                begin
                    why_next   = WHY_USED_UP;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_KIND_RD;
                end
            end
            S_KIND_RD:
            begin
                sreq.rd_addr = pos_reg;
                if (space_reg == '0)
                begin
                    why_next   = WHY_USED_UP;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_KIND;
                end
            end
            S_KIND:
            begin
                priority if (rbyte == KIND_EOL)
                begin
                    why_next   = WHY_END;
                    state_next = S_DONE;
                end
                else if (rbyte == KIND_NOP)
                begin
                    pos_next   = pos_reg + ADDR_W'(1);
                    space_next = space_reg - SPACE_W'(1);
                    state_next = S_KIND_RD;
                end
                else if (rbyte == kind_reg)
                begin
                    sreq.rd_addr = pos_reg + ADDR_W'(2);
                    if (space_reg < SPACE_W'(4))
                    begin
                        why_next   = WHY_SHORT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MAGIC_H;
                    end
                end
                else
                begin
                    sreq.rd_addr = pos_reg + ADDR_W'(1);
                    if (space_reg < SPACE_W'(2))
                    begin
                        why_next   = WHY_SHORT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LEN;
                    end
                end
            end
            S_MAGIC_H:
            begin
                magic_hi_next = rbyte;
                sreq.rd_addr  = pos_reg + ADDR_W'(3);
                state_next    = S_MAGIC_L;
            end
            S_MAGIC_L:
            begin
                sreq.rd_addr = pos_reg + ADDR_W'(1);
                if (magic == magic1_reg || magic == magic2_reg)
                begin
                    state_next = S_XLEN;
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_XLEN:
            begin
                why_next   = space_diff[8] ? WHY_SHORT : WHY_FOUND;
                state_next = S_DONE;
            end
            S_LEN:
            begin
                if (rbyte == 8'd0)
                begin
                    why_next   = WHY_ZERO_LEN;
                    state_next = S_DONE;
                end
                else
                begin
                    if (space_diff[8] || space_diff == 9'd0)
                    begin
                        space_next = '0;
                    end
                    else
                    begin
                        space_next = space_diff[SPACE_W-1:0];
                        pos_next   = pos_reg + ADDR_W'(rbyte[SPACE_W-1:0]);
                    end
                    state_next = S_KIND_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.has_accecn  = (why_reg == WHY_FOUND);
                    out_data_next.exit_reason = why_reg;
                    cnt_next                  = '0;
                    pos_next                  = '0;
                    space_next                = '0;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            space_reg     <= '0;
            why_reg       <= WHY_USED_UP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            space_reg     <= space_next;
            why_reg       <= why_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        magic_hi_reg <= magic_hi_next;
        out_data_reg <= out_data_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(HEADER_BYTES))
        else $error("load count beyond store depth");

    a_found_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.has_accecn == (out_data_reg.exit_reason == WHY_FOUND)))
        else $error("flag and exit reason disagree");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KIND_RD || state_reg == S_KIND || state_reg == S_LEN)
        |-> ({1'b0, pos_reg} + {1'b0, space_reg} <= 7'd60))
        else $error("walk position plus space exceeds option area");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        |=> (cnt_reg == '0 && out_valid_reg))
        else $error("result not posted or load count not restarted");

endmodule

// File: sim/tb_tcp_accecn_option_detector.sv
`timescale 1ns / 100ps
// Testbench for tcp_accecn_option_detector: streams TCP headers byte by byte, predicts
// the AccECN detection result per header and checks it. Depends on acd_pkg and the RTL.
module tb_tcp_accecn_option_detector;
    import acd_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_item_t           in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic [7:0]  hdr_store [HEADER_BYTES];
    int          hdr_count = 0;
    logic [7:0]  cfg_kind = KIND_RESET;
    logic [15:0] cfg_magic1 = MAGIC1_RESET;
    logic [15:0] cfg_magic2 = MAGIC2_RESET;
    out_item_t   detect_q[$];
    int          results_pushed = 0;
    int          err_cnt = 0;

    bit          gaps_on = 1'b1;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;
    int          run_left = 0;

    tcp_accecn_option_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int store_rd(input int idx);
        if (idx < HEADER_BYTES && idx < hdr_count)
            return int'(hdr_store[idx]);
        return 0;
    endfunction

    function automatic why_t walk_options(output logic found);
        int offs;
        int pos;
        int space;
        int kind;
        int len;
        int magic;
        found = 1'b0;
        if (hdr_count < 13)
            return WHY_TRUNC;
        offs = (store_rd(12) >> 4) * 4;
        if (hdr_count < offs)
            return WHY_TRUNC;
        pos = 20;
        space = offs - 20;
        while (space > 0)
        begin
            kind = store_rd(pos);
            if (kind == int'(KIND_EOL))
                return WHY_END;
            if (kind == int'(KIND_NOP))
            begin
                pos++;
                space--;
                continue;
            end
            if (kind == int'(cfg_kind))
            begin
                if (space < 4)
                    return WHY_SHORT;
                magic = (store_rd(pos + 2) << 8) | store_rd(pos + 3);
                if (magic == int'(cfg_magic1) || magic == int'(cfg_magic2))
                begin
                    if (space - store_rd(pos + 1) < 0)
                        return WHY_SHORT;
                    found = 1'b1;
                    return WHY_FOUND;
                end
            end
            if (space < 2)
                return WHY_SHORT;
            len = store_rd(pos + 1);
            if (len == 0)
                return WHY_ZERO_LEN;
            space -= len;
            pos += len;
        end
        return WHY_USED_UP;
    endfunction

    task automatic predict_item(input in_item_t it);
        logic      found;
        why_t      why;
        out_item_t res;
        if (hdr_count < HEADER_BYTES)
        begin
            hdr_store[hdr_count] = it.header_byte;
            hdr_count++;
        end
        if (it.header_end)
        begin
            why = walk_options(found);
            res.has_accecn = found;
            res.exit_reason = why;
            detect_q.push_back(res);
            results_pushed++;
            hdr_count = 0;
        end
    endtask

    task automatic report(input string what, input out_item_t exp, input out_item_t act);
        err_cnt++;
        if (err_cnt <= 10)
            $display({"mismatch (%s): expected has_accecn=%0b exit_reason=%0d, ",
                      "got has_accecn=%0b exit_reason=%0d"},
                     what, exp.has_accecn, exp.exit_reason, act.has_accecn, act.exit_reason);
    endtask

    always @(posedge clk)
    begin
        out_item_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (detect_q.size() == 0)
                report("no result expected", '0, out_data);
            else
            begin
                exp = detect_q.pop_front();
                if (out_data.has_accecn !== exp.has_accecn ||
                    out_data.exit_reason !== exp.exit_reason)
                    report("field", exp, out_data);
            end
        end
    end

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 300);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (run_left == 0)
                begin
                    out_stall <= ~out_stall;
                    run_left <= $urandom_range(1, 15);
                end
                else
                    run_left <= run_left - 1;
            end
        endcase
    end

    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(1, 8) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                in_data <= in_item_t'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        predict_item(it);
    endtask

    task automatic send_header(input byte_q_t hb);
        in_item_t it;
        foreach (hb[i])
        begin
            it.header_byte = hb[i];
            it.header_end = (i == hb.size() - 1);
            send_item(it);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (detect_q.size() != 0);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KIND:   cfg_kind = val[7:0];
            REG_MAGIC1: cfg_magic1 = val[15:0];
            REG_MAGIC2: cfg_magic2 = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [7:0] kind, input logic [15:0] m1,
                                input logic [15:0] m2);
        drain_results();
        repeat (8) @(posedge clk);
        reg_write(REG_KIND, {24'($urandom), kind});
        reg_write(REG_MAGIC1, {16'($urandom), m1});
        reg_write(REG_MAGIC2, {16'($urandom), m2});
    endtask

    function automatic byte_q_t base_header(input int offs);
        byte_q_t h;
        for (int i = 0; i < 20; i++)
            h.push_back(i[0] ? 8'hFF : 8'h00);
        h[12] = {4'(offs), 4'hF};
        return h;
    endfunction

    function automatic byte_q_t make_header();
        byte_q_t h;
        int      offs;
        int      len;
        int      pick;
        int      n;
        logic [15:0] magic;
        if ($urandom_range(0, 19) == 0)
        begin
            n = $urandom_range(1, 70);
            repeat (n) h.push_back(8'($urandom));
            return h;
        end
        offs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 15);
        repeat (20) h.push_back(8'($urandom));
        h[12] = {4'(offs), h[12][3:0]};
        while (h.size() < offs * 4)
        begin
            pick = $urandom_range(0, 11);
            if (pick <= 1)
                h.push_back(KIND_NOP);
            else if (pick == 2)
                h.push_back(($urandom_range(0, 2) == 0) ? KIND_EOL : KIND_NOP);
            else if (pick <= 6)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(4, 12);
                case ($urandom_range(0, 3))
                    0: magic = cfg_magic1;
                    1: magic = cfg_magic2;
                    2: magic = cfg_magic1 ^ (16'h1 << $urandom_range(0, 15));
                    default: magic = 16'($urandom);
                endcase
                h.push_back(cfg_kind);
                h.push_back(8'(len));
                h.push_back(magic[15:8]);
                h.push_back(magic[7:0]);
                for (int i = 4; i < len && i < 16; i++)
                    h.push_back(8'($urandom));
            end
            else if (pick <= 10)
            begin
                pick = $urandom_range(0, 11);
                len = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? $urandom_range(11, 255)
                                                      : $urandom_range(2, 10);
                h.push_back(8'($urandom_range(2, 255)));
                h.push_back(8'(len));
                for (int i = 2; i < len && i < 16; i++)
                    h.push_back(8'($urandom));
            end
            else
                h.push_back(8'($urandom));
        end
        while (h.size() > offs * 4 && h.size() > 20)
            void'(h.pop_back());
        pick = $urandom_range(0, 9);
        if (pick == 8)
        begin
            n = $urandom_range(1, h.size() - 1);
            repeat (n) void'(h.pop_back());
        end
        else if (pick == 9)
        begin
            n = $urandom_range(1, 50);
            repeat (n) h.push_back(8'($urandom));
        end
        return h;
    endfunction

    task automatic run_random(input int n_items);
        int      sent;
        byte_q_t h;
        sent = 0;
        while (sent < n_items)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            h = make_header();
            send_header(h);
            sent += h.size();
            if ($urandom_range(0, 14) == 0)
                drain_results();
        end
    endtask

    task automatic test_directed_cases();
        byte_q_t h;
        h = {8'hFF};
        send_header(h);
        h = base_header(0);
        repeat (7) void'(h.pop_back());
        send_header(h);
        h = base_header(6);
        h = {h, 8'hFE, 8'h04, 8'hAC, 8'hC0};
        send_header(h);
        h = base_header(6);
        h = {h, KIND_NOP, 8'hFE, 8'h05, 8'hAC};
        send_header(h);
        h = base_header(6);
        h = {h, 8'h02, 8'h00, 8'h00, 8'h00};
        send_header(h);
        h = base_header(6);
        h = {h, KIND_EOL, 8'hFF, 8'hFF, 8'hFF};
        send_header(h);
        h = base_header(5);
        send_header(h);
        h = base_header(6);
        h = {h, 8'hFE, 8'h06, 8'hAC, 8'hC1};
        send_header(h);
        h = base_header(7);
        h = {h, 8'hFE, 8'h04, 8'h12, 8'h34, 8'h08, 8'h04, 8'hAC, 8'hC0};
        send_header(h);
        h = base_header(6);
        h = {h, 8'h03, 8'h04, 8'hFF, 8'hFF};
        repeat (44) h.push_back(8'($urandom));
        send_header(h);
        h = base_header(15);
        h = {h, 8'hFE, 8'h04, 8'hAC, 8'hC0};
        send_header(h);
    endtask

    task automatic test_default_registers();
        run_random(200);
    endtask

    task automatic test_reserved_kinds();
        apply_config(KIND_EOL, 16'h0000, 16'hFFFF);
        run_random(250);
        apply_config(KIND_NOP, 16'hFFFF, 16'h0000);
        run_random(250);
    endtask

    task automatic test_magic_extremes();
        apply_config(8'hFF, 16'h0000, 16'hFFFF);
        run_random(250);
    endtask

    task automatic test_random_registers();
        apply_config(8'($urandom_range(2, 253)), 16'($urandom), 16'($urandom));
        run_random(250);
        apply_config(KIND_RESET, MAGIC1_RESET, MAGIC2_RESET);
        run_random(250);
        while (results_pushed < 48)
            run_random(1);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_default_registers();
        test_reserved_kinds();
        test_magic_extremes();
        test_random_registers();
        drain_results();
        repeat (200) @(posedge clk);
        if (err_cnt == 0 && detect_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
